>>> rtl/mrsp_pkg.sv
// Shared types and constants of the MIDI running-status parser.
// No dependencies; the csr, parser, link and top-level files refer to it by scoped names.
`timescale 1ns / 1ps

package mrsp_pkg;

   // Byte classes of the MIDI stream.
   localparam logic [7:0] STATUS_BIT      = 8'h80;
   localparam logic [7:0] REALTIME_FIRST  = 8'hF8;
   localparam logic [7:0] SYSTEM_FIRST    = 8'hF0;
   localparam logic [7:0] CHANNEL_MASK    = 8'h0F;

   // Upper nibbles of channel status bytes.
   localparam logic [3:0] HI_NOTE_OFF     = 4'h8;
   localparam logic [3:0] HI_NOTE_ON      = 4'h9;
   localparam logic [3:0] HI_CONTROL      = 4'hB;
   localparam logic [3:0] HI_PROGRAM      = 4'hC;
   localparam logic [3:0] HI_PRESSURE     = 4'hD;

   // Message lengths, status byte included.
   localparam logic [1:0] LEN_NONE        = 2'd0;
   localparam logic [1:0] LEN_SHORT       = 2'd2;
   localparam logic [1:0] LEN_LONG        = 2'd3;

   // Byte positions inside a message.
   localparam logic [1:0] POS_NONE        = 2'd0;
   localparam logic [1:0] POS_STATUS      = 2'd1;
   localparam logic [1:0] POS_FIRST       = 2'd2;

   // Input word kinds.
   localparam logic       KIND_BYTE       = 1'b0;
   localparam logic       KIND_TICK       = 1'b1;

   // Configuration registers, selected by address bit 2.
   localparam int         CSR_ADDR_W      = 3;
   localparam logic       REG_TIMEOUT     = 1'b0;
   localparam logic       REG_LISTEN      = 1'b1;
   localparam logic [15:0] TIMEOUT_RESET  = 16'd5000;
   localparam logic [4:0] LISTEN_RESET    = 5'd1;
   localparam logic [15:0] IDLE_MAX       = 16'hFFFF;

   typedef enum logic [1:0] {
      MSG_NOTE_OFF = 2'd0,
      MSG_NOTE_ON  = 2'd1,
      MSG_CONTROL  = 2'd2,
      MSG_OTHER    = 2'd3
   } msg_type_type;

   // Configuration seen by the datapath.
   typedef struct packed {
      logic [15:0] timeout_ticks;
      logic [4:0]  listen_channel;
   } cfg_type;

   // What the parser tells the link timer about the current word.
   typedef struct packed {
      logic tick;
      logic done;
   } link_event_type;

   // One result word.
   typedef struct packed {
      logic         msg_valid;
      msg_type_type msg_type;
      logic [4:0]   channel_number;
      logic [6:0]   first_data;
      logic [6:0]   second_data;
      logic         to_listener;
      logic         link_up;
   } result_type;

endpackage

>>> rtl/mrsp_if.sv
// Valid/ready channel interfaces for the request and result words.
// Depends on nothing; used by the top level and by whatever connects to it.
`timescale 1ns / 1ps

// Request channel: one MIDI byte or one millisecond tick per word.
interface mrsp_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] data_byte;

   modport source (output valid, output kind, output data_byte, input ready);
   modport sink (input valid, input kind, input data_byte, output ready);
endinterface

// Result channel: one word per request word.
interface mrsp_rsp_if;
   logic       valid;
   logic       ready;
   logic       msg_valid;
   logic [1:0] msg_type;
   logic [4:0] channel_number;
   logic [6:0] first_data;
   logic [6:0] second_data;
   logic       to_listener;
   logic       link_up;

   modport source (output valid, output msg_valid, output msg_type, output channel_number,
                   output first_data, output second_data, output to_listener,
                   output link_up, input ready);
   modport sink (input valid, input msg_valid, input msg_type, input channel_number,
                 input first_data, input second_data, input to_listener,
                 input link_up, output ready);
endinterface

>>> rtl/mrsp_csr.sv
// APB-style register file holding the link timeout and the listen channel.
// Depends on mrsp_pkg for the register indexes and reset values.
`timescale 1ns / 1ps

module mrsp_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [mrsp_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready,
   output mrsp_pkg::cfg_type               cfg
);

   logic [15:0] timeout_ff, timeout_in;
   logic [4:0]  listen_ff, listen_in;
   logic        write_en;
   logic        reg_sel;

   // Registers are selected by the word address; the byte offset is not decoded.
   assign reg_sel  = paddr[2];
   assign write_en = psel && penable && pwrite;
   assign pready   = 1'b1;

   // Next values of the two registers.
   always_comb begin
      timeout_in = timeout_ff;
      listen_in  = listen_ff;
      if (write_en) begin
         case (reg_sel)
            mrsp_pkg::REG_TIMEOUT: timeout_in = pwdata[15:0];
            mrsp_pkg::REG_LISTEN:  listen_in  = pwdata[4:0];
            default:               timeout_in = timeout_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= mrsp_pkg::TIMEOUT_RESET;
         listen_ff  <= mrsp_pkg::LISTEN_RESET;
      end else begin
         timeout_ff <= timeout_in;
         listen_ff  <= listen_in;
      end
   end

   // Read data is zero-extended.
   always_comb begin
      case (reg_sel)
         mrsp_pkg::REG_TIMEOUT: prdata = {16'd0, timeout_ff};
         mrsp_pkg::REG_LISTEN:  prdata = {27'd0, listen_ff};
         default:               prdata = 32'd0;
      endcase
   end

   assign cfg.timeout_ticks  = timeout_ff;
   assign cfg.listen_channel = listen_ff;

endmodule

>>> rtl/mrsp_parse.sv
// Message assembly with running status, and decoding of completed messages.
// Depends on mrsp_pkg; the state advances only when the word moves to the result register.
`timescale 1ns / 1ps

module mrsp_parse (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     kind,
   input  logic [7:0]               data_byte,
   input  logic [4:0]               listen_channel,
   output mrsp_pkg::link_event_type evt,
   output mrsp_pkg::result_type     result
);

   logic [7:0] status_ff, status_in;
   logic [6:0] held_ff, held_in;
   logic [1:0] pos_ff, pos_in;
   logic [1:0] len_ff, len_in;
   logic       done;
   logic [6:0] d1;
   logic [6:0] d2;
   logic [3:0] hi;
   logic [3:0] byte_hi;
   logic [4:0] chan;
   logic       chan_match;

   assign byte_hi = data_byte[7:4];

   // Assembly state: status bytes load running status, data bytes fill the message.
   always_comb begin
      status_in = status_ff;
      held_in   = held_ff;
      pos_in    = pos_ff;
      len_in    = len_ff;
      done      = 1'b0;
      d1        = 7'd0;
      d2        = 7'd0;
      if (kind == mrsp_pkg::KIND_BYTE) begin
         if ((data_byte & mrsp_pkg::STATUS_BIT) != 8'd0) begin
            if (data_byte >= mrsp_pkg::REALTIME_FIRST) begin
               // Real-time bytes pass through a message untouched.
               pos_in = pos_ff;
            end else if (data_byte >= mrsp_pkg::SYSTEM_FIRST) begin
               pos_in = mrsp_pkg::POS_NONE;
               len_in = mrsp_pkg::LEN_NONE;
            end else begin
               status_in = data_byte;
               pos_in    = mrsp_pkg::POS_STATUS;
               if (byte_hi == mrsp_pkg::HI_PROGRAM || byte_hi == mrsp_pkg::HI_PRESSURE) begin
                  len_in = mrsp_pkg::LEN_SHORT;
               end else begin
                  len_in = mrsp_pkg::LEN_LONG;
               end
            end
         end else if (len_ff != mrsp_pkg::LEN_NONE) begin
            if (pos_ff <= mrsp_pkg::POS_STATUS) begin
               held_in = data_byte[6:0];
               pos_in  = mrsp_pkg::POS_FIRST;
               if (len_ff <= mrsp_pkg::LEN_SHORT) begin
                  d1   = data_byte[6:0];
                  done = 1'b1;
               end
            end else begin
               d1   = held_ff;
               d2   = data_byte[6:0];
               done = 1'b1;
            end
            // Running status stays; the next data byte starts a new message.
            if (done) begin
               pos_in = mrsp_pkg::POS_STATUS;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= 8'd0;
         held_ff   <= 7'd0;
         pos_ff    <= mrsp_pkg::POS_NONE;
         len_ff    <= mrsp_pkg::LEN_NONE;
      end else if (advance) begin
         status_ff <= status_in;
         held_ff   <= held_in;
         pos_ff    <= pos_in;
         len_ff    <= len_in;
      end
   end

   // Decode the completed message from the running status.
   assign hi         = status_ff[7:4];
   assign chan       = {1'b0, status_ff[3:0]} + 5'd1;
   assign chan_match = (chan == listen_channel);

   always_comb begin
      result = '0;
      if (done) begin
         result.msg_valid      = 1'b1;
         result.channel_number = chan;
         result.first_data     = d1;
         result.second_data    = d2;
         case (hi)
            mrsp_pkg::HI_NOTE_OFF: begin
               result.msg_type    = mrsp_pkg::MSG_NOTE_OFF;
               result.to_listener = chan_match;
            end
            mrsp_pkg::HI_NOTE_ON: begin
               // Note on at zero velocity means note off.
               result.msg_type    = (d2 == 7'd0) ? mrsp_pkg::MSG_NOTE_OFF
                                                 : mrsp_pkg::MSG_NOTE_ON;
               result.to_listener = chan_match;
            end
            mrsp_pkg::HI_CONTROL: begin
               result.msg_type    = mrsp_pkg::MSG_CONTROL;
               result.to_listener = 1'b1;
            end
            default: begin
               result.msg_type    = mrsp_pkg::MSG_OTHER;
               result.to_listener = 1'b0;
            end
         endcase
      end
   end

   assign evt.tick = (kind == mrsp_pkg::KIND_TICK);
   assign evt.done = done;

endmodule

>>> rtl/mrsp_link.sv
// Link status: a saturating idle tick counter and the connected flag.
// Depends on mrsp_pkg; driven by the parser's per-word event.
`timescale 1ns / 1ps

module mrsp_link (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  mrsp_pkg::link_event_type evt,
   input  logic [15:0]              timeout_ticks,
   output logic                     link_up
);

   logic [15:0] idle_ff, idle_in;
   logic        conn_ff, conn_in;

   // A message clears the counter and raises the link; a tick ages it and drops the link once it exceeds the timeout.
   always_comb begin
      idle_in = idle_ff;
      conn_in = conn_ff;
      if (evt.done) begin
         idle_in = 16'd0;
         conn_in = 1'b1;
      end else if (evt.tick) begin
         if (idle_ff != mrsp_pkg::IDLE_MAX) begin
            idle_in = idle_ff + 16'd1;
         end
         if (conn_ff && (idle_in > timeout_ticks)) begin
            conn_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_ff <= 16'd0;
         conn_ff <= 1'b0;
      end else if (advance) begin
         idle_ff <= idle_in;
         conn_ff <= conn_in;
      end
   end

   // Status after the current word, for the result register.
   assign link_up = conn_in;

endmodule

>>> rtl/midi_running_status_parser_top.sv
// MIDI running-status parser: input register, parser and link timer, result register.
// Depends on mrsp_pkg, mrsp_if, mrsp_csr, mrsp_parse and mrsp_link.
//
// Usage:
//   The req channel takes one word per cycle while it is not stalled: kind 0 carries
//   a received MIDI byte, kind 1 marks one millisecond tick. The rsp channel returns
//   exactly one word per request word, in order. msg_valid is set when the word
//   completed a note off, note on, control change or other channel message; link_up
//   always reports the connection status after the word.
//   A word accepted into the input register is parsed out of it and appears in the
//   result register when it advances. Throughput is one word per cycle while the
//   receiver takes results, set by the single parse step between the input register
//   and the result register.
//   When the receiver stalls, the result word holds and the input register keeps one
//   more word; req ready drops only while both are full.
//   Reset is synchronous: both registers empty, no message in progress, link down,
//   timeout 5000 ticks, listen channel 1.
//   The csr port is APB-style with registers timeout_ticks at 0x0 and listen_channel
//   at 0x4; write them only while no word is in flight.
`timescale 1ns / 1ps

module midi_running_status_parser_top (
   input  logic                            clock,
   input  logic                            reset,
   mrsp_req_if.sink                        req_ch,
   mrsp_rsp_if.source                      rsp_ch,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [mrsp_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);

   mrsp_pkg::cfg_type        cfg;
   mrsp_pkg::link_event_type evt;
   mrsp_pkg::result_type     parsed;
   mrsp_pkg::result_type     out_ff;
   mrsp_pkg::result_type     out_in;
   logic                     link_up_next;

   logic       in_valid_ff, in_valid_in;
   logic       in_kind_ff;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff, out_valid_in;
   logic       advance;
   logic       req_fire;

   // The input word moves on whenever the result register is free or being drained.
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign in_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_ff);

   // Control state of both registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input payload register.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_kind_ff <= req_ch.kind;
         in_byte_ff <= req_ch.data_byte;
      end
   end

   mrsp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   mrsp_parse u_parse (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .kind           (in_kind_ff),
      .data_byte      (in_byte_ff),
      .listen_channel (cfg.listen_channel),
      .evt            (evt),
      .result         (parsed)
   );

   mrsp_link u_link (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .evt           (evt),
      .timeout_ticks (cfg.timeout_ticks),
      .link_up       (link_up_next)
   );

   // Result word with the link status after this word.
   always_comb begin
      out_in         = parsed;
      out_in.link_up = link_up_next;
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.msg_valid      = out_ff.msg_valid;
   assign rsp_ch.msg_type       = out_ff.msg_type;
   assign rsp_ch.channel_number = out_ff.channel_number;
   assign rsp_ch.first_data     = out_ff.first_data;
   assign rsp_ch.second_data    = out_ff.second_data;
   assign rsp_ch.to_listener    = out_ff.to_listener;
   assign rsp_ch.link_up        = out_ff.link_up;

`ifndef SYNTHESIS
   // A completed message always leaves the link up.
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.msg_valid |-> rsp_ch.link_up)
      else $error("message reported with link down");

   // Without a message every message field is zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.msg_valid |->
         rsp_ch.msg_type == mrsp_pkg::MSG_NOTE_OFF && rsp_ch.channel_number == 5'd0 &&
         rsp_ch.first_data == 7'd0 && rsp_ch.second_data == 7'd0 && !rsp_ch.to_listener)
      else $error("stray message fields without a message");

   // Other channel messages never go to the listener; real messages carry a channel.
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.msg_valid && rsp_ch.msg_type == mrsp_pkg::MSG_OTHER |->
         !rsp_ch.to_listener && rsp_ch.channel_number != 5'd0)
      else $error("other message flagged for the listener");

   // Request ready only drops when the input register holds a stalled word.
   assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> in_valid_ff && out_valid_ff && !rsp_ch.ready)
      else $error("request stalled without a full pipeline");

   // A word advancing from the input register reaches the result register next.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_ch.valid)
      else $error("parsed word lost before the result register");
`endif

endmodule
